/* rtl/rgbhsl_pkg.sv */
`default_nettype none

package rgbhsl_pkg;

	// Pixel and result formats.
	localparam int CH_W          = 8;
	localparam int CH_MAX        = (1 << CH_W) - 1;
	localparam int HUE_FRAC_BITS = 6;
	localparam int FRACTION_BITS = 12;
	localparam int HUE_W         = 15;
	localparam int FRAC_W        = FRACTION_BITS;

	// Full scale of a fraction and the hue unit of one 60 degree sector.
	localparam int FRAC_FS   = (1 << FRACTION_BITS) - 1;
	localparam int HUE_UNIT  = 60 << HUE_FRAC_BITS;
	localparam int SECTORS   = 6;
	localparam int HUE_FULL  = SECTORS * HUE_UNIT;

	// Hue offsets in sectors for each dominant channel.
	localparam int OFS_W        = 3;
	localparam int OFS_RED      = 0;
	localparam int OFS_RED_WRAP = SECTORS;
	localparam int OFS_GREEN    = 2;
	localparam int OFS_BLUE     = 4;

	// Shared restoring divider geometry. Every quotient that the block needs
	// stays below 2^DIV_Q_W, and the divisor shifted by DIV_Q_W-1 fits the
	// numerator width.
	localparam int DIV_NUM_W = 24;
	localparam int DIV_DEN_W = 10;
	localparam int DIV_Q_W   = 15;

	// Lightness divides by the constant 2 * (2 * CH_MAX): a shift by two, then a
	// multiplication by the reciprocal of CH_MAX, rounded up at 2^-LIGHT_SHIFT.
	// The shifted numerator stays below 2^LIGHT_Y_W, and over that range the
	// product gives the exact floor.
	localparam int LIGHT_PRE_SHIFT = 2;
	localparam int LIGHT_Y_W       = 20;
	localparam int LIGHT_SHIFT     = 28;
	localparam int LIGHT_RECIP     = ((1 << LIGHT_SHIFT) + CH_MAX - 1) / CH_MAX;
	localparam int LIGHT_RECIP_W   = 21;

	// One division request: rounded quotient of num / den, with the rounding
	// term already folded into num and den doubled.
	typedef struct packed {
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	// Requests that the front end hands to the divider lanes.
	typedef struct packed {
		div_req_t               hue;
		div_req_t               sat;
		logic [DIV_NUM_W-1:0]   light_num;
	} front_out_t;

endpackage

`default_nettype wire

/* rtl/rgbhsl_front.sv */
`default_nettype none

module rgbhsl_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          pix_valid,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]   red,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]   green,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]   blue,
	output logic                               vld,
	output rgbhsl_pkg::front_out_t             req
);
	import rgbhsl_pkg::*;

	logic [CH_W-1:0]  mx, mn, da, db;
	logic [OFS_W-1:0] ofs;

	logic              vld_s1;
	logic [CH_W-1:0]   delta_s1;
	logic [CH_W:0]     sum_s1;
	logic [CH_W-1:0]   diff_s1;
	logic              neg_s1;
	logic [OFS_W-1:0]  ofs_s1;

	logic                      vld_s2;
	front_out_t                req_s2;

	logic [CH_W+OFS_W-1:0]     t;
	logic [CH_W:0]             sat_den;

	// Stage 1: extremes of the three channels and the sector of the hue.
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (mx == red) begin
			da  = green;
			db  = blue;
			ofs = (green >= blue) ? OFS_W'(OFS_RED) : OFS_W'(OFS_RED_WRAP);
		end else if (mx == green) begin
			da  = blue;
			db  = red;
			ofs = OFS_W'(OFS_GREEN);
		end else begin
			da  = red;
			db  = green;
			ofs = OFS_W'(OFS_BLUE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			delta_s1 <= mx - mn;
			sum_s1   <= {1'b0, mx} + {1'b0, mn};
			neg_s1   <= (da < db);
			diff_s1  <= (da < db) ? (db - da) : (da - db);
			ofs_s1   <= ofs;
		end
	end

	// Stage 2: numerators and divisors of the three rounded divisions.
	always_comb begin
		t = (CH_W+OFS_W)'(ofs_s1) * (CH_W+OFS_W)'(delta_s1);
		if (neg_s1) begin
			t = t - (CH_W+OFS_W)'(diff_s1);
		end else begin
			t = t + (CH_W+OFS_W)'(diff_s1);
		end
		sat_den = (sum_s1 <= (CH_W+1)'(CH_MAX)) ? sum_s1
			: ((CH_W+1)'(2 * CH_MAX) - sum_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s2.light_num <= DIV_NUM_W'(sum_s1) * DIV_NUM_W'(2 * FRAC_FS)
				+ DIV_NUM_W'(2 * CH_MAX);
			if (delta_s1 == '0) begin
				// A gray pixel gives zero hue and zero saturation.
				req_s2.hue.num <= '0;
				req_s2.hue.den <= DIV_DEN_W'(1);
				req_s2.sat.num <= '0;
				req_s2.sat.den <= DIV_DEN_W'(1);
			end else begin
				req_s2.hue.num <= DIV_NUM_W'(t) * DIV_NUM_W'(2 * HUE_UNIT)
					+ DIV_NUM_W'(delta_s1);
				req_s2.hue.den <= DIV_DEN_W'({delta_s1, 1'b0});
				req_s2.sat.num <= DIV_NUM_W'(delta_s1) * DIV_NUM_W'(2 * FRAC_FS)
					+ DIV_NUM_W'(sat_den);
				req_s2.sat.den <= DIV_DEN_W'({sat_den, 1'b0});
			end
		end
	end

	assign vld = vld_s2;
	assign req = req_s2;

endmodule

`default_nettype wire

/* rtl/rgbhsl_div.sv */
`default_nettype none

module rgbhsl_div (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [rgbhsl_pkg::DIV_NUM_W-1:0]  num,
	input  wire logic [rgbhsl_pkg::DIV_DEN_W-1:0]  den,
	output logic [rgbhsl_pkg::DIV_Q_W-1:0]         quo
);
	import rgbhsl_pkg::*;

	// One quotient bit per stage, most significant bit first.
	logic [DIV_NUM_W-1:0] rem_s [DIV_Q_W-1];
	logic [DIV_DEN_W-1:0] den_s [DIV_Q_W-1];
	logic [DIV_Q_W-1:0]   quo_s [DIV_Q_W];

	for (genvar k = 0; k < DIV_Q_W; k++) begin : g_stage
		logic [DIV_NUM_W-1:0] rem_i;
		logic [DIV_NUM_W-1:0] dsh;
		logic [DIV_DEN_W-1:0] den_i;
		logic [DIV_Q_W-1:0]   quo_i;
		logic                 ge;

		if (k == 0) begin : g_first
			assign rem_i = num;
			assign den_i = den;
			assign quo_i = '0;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign quo_i = quo_s[k-1];
		end

		assign dsh = DIV_NUM_W'(den_i) << (DIV_Q_W - 1 - k);
		assign ge  = (rem_i >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= quo_i | (ge ? (DIV_Q_W'(1) << (DIV_Q_W - 1 - k)) : '0);
			end
		end

		if (k < DIV_Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? (rem_i - dsh) : rem_i;
					den_s[k] <= den_i;
				end
			end
		end
	end

	assign quo = quo_s[DIV_Q_W-1];

endmodule

`default_nettype wire

/* rtl/rgb_to_hsl_converter.sv */
`default_nettype none

// RGB to HSL converter for 8-bit pixels. Each word on the pixel side carries
// red, green and blue; each word on the result side carries hue in 1/64 degree
// (0 up to 23039), and saturation and lightness as 12-bit fractions where 4095
// stands for 1.0, all rounded to nearest. The block takes one pixel every
// clock while the pixel side is not stalled and carries each pixel through 18
// register stages: two front-end stages find the extremes of the channels and
// build the numerators, two restoring dividers for hue and saturation working
// side by side spend fifteen stages at one quotient bit each, lightness, whose
// divisor is fixed, is taken by a reciprocal product and delayed alongside
// them, and one final stage wraps the hue into range and holds the output
// word. When the result side stalls a valid word, the whole pipeline freezes
// and the pixel side is stalled in the same cycle; nothing is lost or
// repeated.

module rgb_to_hsl_converter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pix_valid,
	output logic                                 pix_stall,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]     red,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]     green,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]     blue,
	output logic                                 hsl_valid,
	input  wire logic                            hsl_stall,
	output logic [rgbhsl_pkg::HUE_W-1:0]         hue,
	output logic [rgbhsl_pkg::FRAC_W-1:0]        saturation,
	output logic [rgbhsl_pkg::FRAC_W-1:0]        lightness
);
	import rgbhsl_pkg::*;

	// All stages move together unless a finished word is held at the output.
	logic       en;
	logic       front_vld;
	front_out_t front_req;

	logic [DIV_Q_W-1:0] hue_quo, sat_quo;

	// Lightness: the numerator over four times the reciprocal of CH_MAX, then a
	// delay line that keeps it level with the two dividers.
	logic [LIGHT_Y_W-1:0]               light_y;
	logic [LIGHT_Y_W+LIGHT_RECIP_W-1:0] light_prod;
	logic [FRAC_W-1:0]                  light_s [DIV_Q_W];

	// Valid bits that travel alongside the divider stages.
	logic [DIV_Q_W-1:0] div_vld_q;

	logic              valid_q;
	logic [HUE_W-1:0]  hue_q;
	logic [FRAC_W-1:0] sat_q;
	logic [FRAC_W-1:0] light_q;

	assign en        = !(valid_q && hsl_stall);
	assign pix_stall = !en;

	rgbhsl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.pix_valid (pix_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.vld       (front_vld),
		.req       (front_req)
	);

	// Hue: offset and signed difference over delta.
	rgbhsl_div u_div_hue (
		.clk (clk),
		.en  (en),
		.num (front_req.hue.num),
		.den (front_req.hue.den),
		.quo (hue_quo)
	);

	// Saturation: delta over the lightness-dependent denominator.
	rgbhsl_div u_div_sat (
		.clk (clk),
		.en  (en),
		.num (front_req.sat.num),
		.den (front_req.sat.den),
		.quo (sat_quo)
	);

	// The first delay stage takes the quotient in the same slot as the first
	// divider stage, so all three fields reach the output stage together.
	assign light_y    = LIGHT_Y_W'(front_req.light_num >> LIGHT_PRE_SHIFT);
	assign light_prod = (LIGHT_Y_W+LIGHT_RECIP_W)'(light_y)
		* (LIGHT_Y_W+LIGHT_RECIP_W)'(LIGHT_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			light_s[0] <= FRAC_W'(light_prod >> LIGHT_SHIFT);
			for (int i = 1; i < DIV_Q_W; i++) begin
				light_s[i] <= light_s[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_q <= '0;
			valid_q   <= 1'b0;
		end else if (en) begin
			div_vld_q <= {div_vld_q[DIV_Q_W-2:0], front_vld};
			valid_q   <= div_vld_q[DIV_Q_W-1];
		end
	end

	// A hue that rounds up to a full turn wraps to zero.
	always_ff @(posedge clk) begin
		if (en) begin
			if (hue_quo >= DIV_Q_W'(HUE_FULL)) begin
				hue_q <= HUE_W'(hue_quo - DIV_Q_W'(HUE_FULL));
			end else begin
				hue_q <= HUE_W'(hue_quo);
			end
			sat_q   <= FRAC_W'(sat_quo);
			light_q <= light_s[DIV_Q_W-1];
		end
	end

	assign hsl_valid  = valid_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign lightness  = light_q;

endmodule

`default_nettype wire

/* rtl/rgbhsl_checker.sv */
`default_nettype none

module rgbhsl_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pix_valid,
	input  wire logic                            pix_stall,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]     red,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]     green,
	input  wire logic [rgbhsl_pkg::CH_W-1:0]     blue,
	input  wire logic                            hsl_valid,
	input  wire logic                            hsl_stall,
	input  wire logic [rgbhsl_pkg::HUE_W-1:0]    hue,
	input  wire logic [rgbhsl_pkg::FRAC_W-1:0]   saturation,
	input  wire logic [rgbhsl_pkg::FRAC_W-1:0]   lightness
);
	import rgbhsl_pkg::*;

	// A stalled result word stays valid and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && hsl_stall |=> hsl_valid && $stable(hue)
			&& $stable(saturation) && $stable(lightness))
		else $error("stalled result word changed");

	// The pixel side is held back exactly when a result word is stalled.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall == (hsl_valid && hsl_stall))
		else $error("pixel stall does not follow the result stall");

	// Hue always lies below a full turn.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> hue < HUE_W'(HUE_FULL))
		else $error("hue out of range");

	// A nonzero hue always comes with nonzero saturation.
	a_hue_sat: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && hue != '0 |-> saturation != '0)
		else $error("nonzero hue with zero saturation");

	// Black has neither hue nor saturation.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && lightness == '0 |-> saturation == '0 && hue == '0)
		else $error("black pixel with hue or saturation");

endmodule

bind rgb_to_hsl_converter rgbhsl_checker u_rgbhsl_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none

// Testbench of the RGB to HSL converter. Every pixel that is accepted goes to a
// predictor that works out hue, saturation and lightness in the block's fixed
// point formats. The expected word waits in a queue until the result side
// accepts a word, and the two are then compared field by field. Both sides idle
// and stall at random. A watchdog ends the run when no word moves for too long.

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbhsl_pkg::*;

	// Pipeline depth given by the block, and how long the run may go on with no
	// word moving on either side before it is declared hung.
	localparam int PIPE_DEPTH  = 18;
	localparam int HANG_LIMIT  = 4000;
	localparam int MAX_REPORTS = 10;

	// One result word as the block presents it.
	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [FRAC_W-1:0] saturation;
		logic [FRAC_W-1:0] lightness;
	} hsl_word_t;

	// Every input of the block is known from time zero on.
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              pix_valid = 1'b0;
	logic [CH_W-1:0]   red       = '0;
	logic [CH_W-1:0]   green     = '0;
	logic [CH_W-1:0]   blue      = '0;
	logic              hsl_stall = 1'b0;
	logic              pix_stall;
	logic              hsl_valid;
	logic [HUE_W-1:0]  hue;
	logic [FRAC_W-1:0] saturation;
	logic [FRAC_W-1:0] lightness;

	// Expected words in the order the pixels were accepted.
	hsl_word_t pending_hsl_q[$];

	int fail_count = 0;
	int word_count = 0;
	int idle_cycles = 0;

	// When set, the matching side runs without any gaps. Tests flip these now
	// and then so that long unbroken stretches alternate with ragged ones.
	bit pix_steady = 1'b0;
	bit hsl_steady = 1'b0;

	rgb_to_hsl_converter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.hsl_valid  (hsl_valid),
		.hsl_stall  (hsl_stall),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Rounded division, halves going up, done exactly in integers.
	function automatic int unsigned nearest_div(input int unsigned num, input int unsigned den);
		return (2 * num + den) / (2 * den);
	endfunction

	// Predicts the result word of one pixel. The channel that holds the maximum
	// picks the hue sector, red winning ties over green and green over blue.
	// A red-sector hue that would go negative is moved up by a full turn.
	function automatic hsl_word_t predict_hsl(input logic [CH_W-1:0] r, g, b);
		int unsigned rv, gv, bv, top, bottom, spread, sum;
		int unsigned sector_ofs, rise, fall, num, hue_q, sat_den;
		hsl_word_t w;
		rv = 32'(r);
		gv = 32'(g);
		bv = 32'(b);
		top = rv;
		if (gv > top) top = gv;
		if (bv > top) top = bv;
		bottom = rv;
		if (gv < bottom) bottom = gv;
		if (bv < bottom) bottom = bv;
		spread = top - bottom;
		sum = top + bottom;
		w.lightness = FRAC_W'(nearest_div(sum * FRAC_FS, 2 * CH_MAX));
		w.hue = '0;
		w.saturation = '0;
		// A gray pixel has no hue and no saturation.
		if (spread != 0) begin
			if (top == rv) begin
				sector_ofs = (gv >= bv) ? OFS_RED : OFS_RED_WRAP;
				rise = gv;
				fall = bv;
			end else if (top == gv) begin
				sector_ofs = OFS_GREEN;
				rise = bv;
				fall = rv;
			end else begin
				sector_ofs = OFS_BLUE;
				rise = rv;
				fall = gv;
			end
			// The offset term always covers the subtraction, so this stays positive.
			num = sector_ofs * HUE_UNIT * spread + HUE_UNIT * rise - HUE_UNIT * fall;
			hue_q = nearest_div(num, spread);
			// A hue that rounds up to a full turn is folded back to zero.
			if (hue_q >= HUE_FULL) hue_q -= HUE_FULL;
			w.hue = HUE_W'(hue_q);
			sat_den = (sum <= CH_MAX) ? sum : 2 * CH_MAX - sum;
			w.saturation = FRAC_W'(nearest_div(spread * FRAC_FS, sat_den));
		end
		return w;
	endfunction

	// Picks new pacing for both sides: mostly ragged, sometimes without gaps.
	task automatic shuffle_pacing();
		pix_steady = ($urandom_range(0, 3) == 0);
		hsl_steady = ($urandom_range(0, 3) == 0);
	endtask

	// Sends one pixel word. It is called and returns at a rising edge. Valid is
	// only lowered when a gap is actually drawn, so a word that follows at once
	// keeps valid high without a second assignment in the same step.
	task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
		int gap;
		gap = pix_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red       <= r;
		green     <= g;
		blue      <= b;
		do @(posedge clk); while (pix_stall);
		pending_hsl_q.push_back(predict_hsl(r, g, b));
	endtask

	// Stops sending and waits until every expected word has come back.
	task automatic drain_results();
		pix_valid <= 1'b0;
		while (pending_hsl_q.size() != 0) @(posedge clk);
	endtask

	// Extremes of the channels, the primary and secondary colors, ties for the
	// maximum, red-sector hues that wrap, gray pixels, and pixels right around
	// the point where the saturation divisor changes form.
	task automatic test_corner_pixels();
		logic [23:0] corners [0:23] = '{
			24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFEFEFE, 24'h7F7F7F,
			24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00,
			24'hFF0001, 24'hFF0100, 24'hFFFF01, 24'h01FFFF, 24'hFF01FF, 24'h807F7F,
			24'h7F8080, 24'h818080, 24'hAA55AA, 24'h55AA55, 24'h000001, 24'hFE00FF
		};
		foreach (corners[i])
			send_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);
	endtask

	// Walks all six orderings of the channels, with a fair share of ties
	// between the middle channel and one of the extremes.
	task automatic test_sector_sweep();
		logic [CH_W-1:0] hi, lo, mid;
		int order;
		for (int n = 0; n < 150; n++) begin
			hi = CH_W'($urandom_range(1, 255));
			lo = CH_W'($urandom_range(0, hi - 1));
			case ($urandom_range(0, 3))
				0: mid = hi;
				1: mid = lo;
				default: mid = CH_W'($urandom_range(lo, hi));
			endcase
			order = n % 6;
			case (order)
				0: send_pixel(hi, mid, lo);
				1: send_pixel(hi, lo, mid);
				2: send_pixel(mid, hi, lo);
				3: send_pixel(lo, hi, mid);
				4: send_pixel(mid, lo, hi);
				default: send_pixel(lo, mid, hi);
			endcase
			if (n % 50 == 49) shuffle_pacing();
		end
	endtask

	// Nearly gray pixels: the spread is tiny, so the hue division works with
	// its smallest divisors and rounding decides most of the result.
	task automatic test_near_gray();
		logic [CH_W-1:0] base;
		for (int n = 0; n < 300; n++) begin
			base = CH_W'($urandom_range(0, 252));
			send_pixel(base + CH_W'($urandom_range(0, 3)), base + CH_W'($urandom_range(0, 3)),
				base + CH_W'($urandom_range(0, 3)));
			if (n % 60 == 59) shuffle_pacing();
		end
	endtask

	// Uniform random pixels, with the pacing of both sides changed every
	// hundred words.
	task automatic test_random_pixels();
		for (int n = 0; n < 1400; n++) begin
			if (n % 100 == 0) shuffle_pacing();
			send_pixel(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
				CH_W'($urandom_range(0, 255)));
		end
	endtask

	// Short bursts, each followed by a full drain, so that the pipeline runs
	// empty and fills up again from nothing.
	task automatic test_burst_and_drain();
		for (int k = 0; k < 3; k++) begin
			pix_steady = (k != 1);
			for (int n = 0; n < 16; n++)
				send_pixel(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
					CH_W'($urandom_range(0, 255)));
			drain_results();
		end
	endtask

	// Result side: for every word it draws a number of cycles to hold stall
	// high, then takes the next word that comes and checks it against the
	// oldest expectation.
	initial begin
		hsl_word_t seen, want;
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = hsl_steady ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				hsl_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			hsl_stall <= 1'b0;
			do @(posedge clk); while (hsl_valid !== 1'b1);
			seen = '{hue: hue, saturation: saturation, lightness: lightness};
			word_count++;
			if (pending_hsl_q.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("word %0d arrived with no pixel pending: hue %0d sat %0d light %0d",
						word_count, seen.hue, seen.saturation, seen.lightness);
			end else begin
				want = pending_hsl_q.pop_front();
				if (seen !== want) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("word %0d: expected hue %0d sat %0d light %0d, got hue %0d sat %0d light %0d",
							word_count, want.hue, want.saturation, want.lightness,
							seen.hue, seen.saturation, seen.lightness);
				end
			end
		end
	end

	// Watchdog: counts edges at which neither side moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_valid && !pix_stall) || (hsl_valid && !hsl_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Main sequence: reset, the tests in turn, then a drain and a short tail in
	// which any stray word would still be caught.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_pixels();
		test_sector_sweep();
		test_burst_and_drain();
		test_near_gray();
		test_random_pixels();
		drain_results();
		repeat (PIPE_DEPTH + 8) @(posedge clk);
		if (fail_count == 0 && pending_hsl_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

/* rgb_to_hsl_converter.f */
rtl/rgbhsl_pkg.sv
rtl/rgbhsl_front.sv
rtl/rgbhsl_div.sv
rtl/rgb_to_hsl_converter.sv
rtl/rgbhsl_checker.sv
sim/tb_top.sv
